FILE: rtl/core/cartesian_to_polar_core_defines.svh
// ----------------------------------------------------------------------------
// cartesian_to_polar_core_defines
// assertion macros shared by the cartesian to polar core
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_CORE_DEFINES_SVH
`define CARTESIAN_TO_POLAR_CORE_DEFINES_SVH

// condition in the same cycle implies consequence
`define C2P_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must never be seen
`define C2P_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: rtl/core/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg
// widths, constants and pipeline payload types of the cartesian to polar core
// ----------------------------------------------------------------------------
package c2p_pkg;

   // field widths
   localparam int COORD_BITS     = 20;
   localparam int ANGLE_BITS     = 16;
   localparam int ROTATION_STEPS = 16;
   localparam int XFLOOR_BITS    = COORD_BITS - 4;

   // cordic datapath: magnitude shifted up by guard bits, headroom for gain
   localparam int GUARD_SHIFT  = 8;
   localparam int CORDIC_BITS  = COORD_BITS + GUARD_SHIFT + 2;
   localparam int ZACC_BITS    = 32;
   localparam int ATAN_ENTRIES = 24;

   // inverse gain multiply split into high and low partial products
   localparam int INV_BITS      = 32;
   localparam int LO_SPLIT      = 16;
   localparam int HI_BITS       = CORDIC_BITS - 1 - LO_SPLIT;
   localparam int HI_PROD_BITS  = HI_BITS + INV_BITS;
   localparam int LO_PROD_BITS  = LO_SPLIT + INV_BITS;
   localparam int SUM_BITS      = HI_PROD_BITS + 1;
   localparam int MAG_SHIFT     = LO_SPLIT + GUARD_SHIFT;
   localparam int MAG_WIDE_BITS = SUM_BITS - MAG_SHIFT;

   localparam logic [63:0] INV_GAIN_BASE = 64'd2608131496;
   localparam logic [63:0] INV_GAIN_WIDE =
      INV_GAIN_BASE + ((64'd2 * INV_GAIN_BASE / 64'd3) >> (2 * ROTATION_STEPS));
   localparam logic [INV_BITS-1:0] INV_GAIN = INV_GAIN_WIDE[INV_BITS-1:0];

   localparam logic [SUM_BITS-1:0] MAG_ROUND = SUM_BITS'(1) << (MAG_SHIFT - 1);
   localparam logic [MAG_WIDE_BITS-1:0] MAG_MAX =
      MAG_WIDE_BITS'((64'd1 << COORD_BITS) - 64'd1);
   localparam logic [COORD_BITS-1:0] MAG_ONE = COORD_BITS'(16);
   localparam logic [XFLOOR_BITS-1:0] XFLOOR_ORIGIN = XFLOOR_BITS'(1);

   // angle accumulator: 2^32 units per turn
   localparam logic [ZACC_BITS-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [ZACC_BITS-1:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [ZACC_BITS-1:0] THREEQ_TURN  = 32'hC000_0000;
   localparam logic [ZACC_BITS:0]   ANGLE_ROUND  =
      (ZACC_BITS+1)'(1) << (ZACC_BITS - 1 - ANGLE_BITS);

   // output angle codes for quadrant limits
   localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
   localparam logic [ANGLE_BITS-1:0] ANGLE_THREEQ  = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

   // arctan(2^-i) in turn units, rounded to nearest
   localparam logic [ZACC_BITS-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // per-point flags that ride along the pipeline
   typedef struct packed {
      logic                   origin;
      logic                   x_zero;
      logic                   y_zero;
      logic                   x_neg;
      logic                   y_neg;
      logic [XFLOOR_BITS-1:0] x_floor;
   } side_type;

   // cordic working set of one point
   typedef struct packed {
      logic signed [CORDIC_BITS-1:0] cx;
      logic signed [CORDIC_BITS-1:0] cy;
      logic signed [ZACC_BITS-1:0]   z;
      side_type                      side;
   } cordic_type;

endpackage

FILE: rtl/core/c2p_req_if.sv
// ----------------------------------------------------------------------------
// c2p_req_if
// request channel: one point per transfer
// ----------------------------------------------------------------------------
interface c2p_req_if;
   import c2p_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] x_coord;
   logic signed [COORD_BITS-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

FILE: rtl/core/c2p_rsp_if.sv
// ----------------------------------------------------------------------------
// c2p_rsp_if
// response channel: magnitude, angle and x floor of one point
// ----------------------------------------------------------------------------
interface c2p_rsp_if;
   import c2p_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [COORD_BITS-1:0]         magnitude;
   logic [ANGLE_BITS-1:0]         angle;
   logic signed [XFLOOR_BITS-1:0] x_floor;

   modport source (output valid, output magnitude, output angle, output x_floor,
                   input ready);
   modport sink (input valid, input magnitude, input angle, input x_floor,
                 output ready);
endinterface

FILE: rtl/core/c2p_prep.sv
// ----------------------------------------------------------------------------
// c2p_prep
// input stage: absolute values, guard shift and special-case flags
// ----------------------------------------------------------------------------
module c2p_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [c2p_pkg::COORD_BITS-1:0] x_coord,
   input  logic signed [c2p_pkg::COORD_BITS-1:0] y_coord,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output c2p_pkg::cordic_type                   out_data
);
   import c2p_pkg::*;

   logic                          valid_ff;
   cordic_type                    data_ff;
   cordic_type                    data_in;
   logic signed [CORDIC_BITS-1:0] x_ext;
   logic signed [CORDIC_BITS-1:0] y_ext;
   logic signed [CORDIC_BITS-1:0] x_abs;
   logic signed [CORDIC_BITS-1:0] y_abs;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // folding into the first quadrant
   always_comb begin
      x_ext = CORDIC_BITS'(x_coord);
      y_ext = CORDIC_BITS'(y_coord);
      x_abs = x_coord[COORD_BITS-1] ? -x_ext : x_ext;
      y_abs = y_coord[COORD_BITS-1] ? -y_ext : y_ext;

      data_in.cx             = x_abs <<< GUARD_SHIFT;
      data_in.cy             = y_abs <<< GUARD_SHIFT;
      data_in.z              = '0;
      data_in.side.x_zero    = (x_coord == '0);
      data_in.side.y_zero    = (y_coord == '0);
      data_in.side.origin    = (x_coord == '0) && (y_coord == '0);
      data_in.side.x_neg     = x_coord[COORD_BITS-1];
      data_in.side.y_neg     = y_coord[COORD_BITS-1];
      // floor(x / 16) is the arithmetic shift, zero stays zero
      data_in.side.x_floor   = x_coord[COORD_BITS-1:4];
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end
endmodule

FILE: rtl/core/c2p_cordic.sv
// ----------------------------------------------------------------------------
// c2p_cordic
// vectoring cordic, one register stage per rotation
// ----------------------------------------------------------------------------
module c2p_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  c2p_pkg::cordic_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output c2p_pkg::cordic_type out_data
);
   import c2p_pkg::*;

   localparam int NS = ROTATION_STEPS;

   logic       stage_valid_ff [NS];
   cordic_type stage_data_ff  [NS];
   cordic_type stage_data_in  [NS];
   logic       pipe_valid     [NS+1];
   logic       pipe_ready     [NS+1];
   cordic_type pipe_data      [NS+1];

   // stage links and the ready chain
   always_comb begin
      pipe_valid[0] = in_valid;
      pipe_data[0]  = in_data;
      for (int k = 0; k < NS; k++) begin
         pipe_valid[k+1] = stage_valid_ff[k];
         pipe_data[k+1]  = stage_data_ff[k];
      end
      pipe_ready[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         pipe_ready[k] = !stage_valid_ff[k] || pipe_ready[k+1];
      end
   end

   assign in_ready  = pipe_ready[0];
   assign out_valid = pipe_valid[NS];
   assign out_data  = pipe_data[NS];

   // one rotation per stage, direction from the sign of y
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         stage_data_in[k] = pipe_data[k];
         if (!pipe_data[k].cy[CORDIC_BITS-1]) begin
            stage_data_in[k].cx = pipe_data[k].cx + (pipe_data[k].cy >>> k);
            stage_data_in[k].cy = pipe_data[k].cy - (pipe_data[k].cx >>> k);
            stage_data_in[k].z  = pipe_data[k].z + signed'(ATAN_TABLE[k]);
         end else begin
            stage_data_in[k].cx = pipe_data[k].cx - (pipe_data[k].cy >>> k);
            stage_data_in[k].cy = pipe_data[k].cy + (pipe_data[k].cx >>> k);
            stage_data_in[k].z  = pipe_data[k].z - signed'(ATAN_TABLE[k]);
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            stage_valid_ff[k] <= 1'b0;
         end
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (pipe_ready[k]) begin
               stage_valid_ff[k] <= pipe_valid[k];
            end
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (pipe_ready[k] && pipe_valid[k]) begin
            stage_data_ff[k] <= stage_data_in[k];
         end
      end
   end
endmodule

FILE: rtl/core/c2p_gain.sv
// ----------------------------------------------------------------------------
// c2p_gain
// gain correction, quadrant placement, rounding and the output register
// ----------------------------------------------------------------------------
module c2p_gain (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  c2p_pkg::cordic_type                    in_data,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [c2p_pkg::COORD_BITS-1:0]         magnitude,
   output logic [c2p_pkg::ANGLE_BITS-1:0]         angle,
   output logic signed [c2p_pkg::XFLOOR_BITS-1:0] x_floor
);
   import c2p_pkg::*;

   // multiply stage registers
   logic                      mul_valid_ff;
   logic [HI_PROD_BITS-1:0]   hi_ff;
   logic [LO_PROD_BITS-1:0]   lo_ff;
   logic [ZACC_BITS-1:0]      ang_ff;
   side_type                  side_ff;
   logic                      mul_ready;

   // output registers
   logic                      rsp_valid_ff;
   logic [COORD_BITS-1:0]     mag_ff;
   logic [ANGLE_BITS-1:0]     angle_ff;
   logic [XFLOOR_BITS-1:0]    xfl_ff;
   logic                      rsp_ready;

   logic [HI_BITS-1:0]        hi_src;
   logic [LO_SPLIT-1:0]       lo_src;
   logic [HI_PROD_BITS-1:0]   hi_in;
   logic [LO_PROD_BITS-1:0]   lo_in;
   logic [ZACC_BITS-1:0]      z_clamp;
   logic [ZACC_BITS-1:0]      ang_in;
   logic [SUM_BITS-1:0]       mag_sum;
   logic [MAG_WIDE_BITS-1:0]  mag_wide;
   logic [ZACC_BITS:0]        ang_round;
   logic [COORD_BITS-1:0]     mag_in;
   logic [ANGLE_BITS-1:0]     angle_in;
   logic [XFLOOR_BITS-1:0]    xfl_in;

   assign rsp_ready = !rsp_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || rsp_ready;
   assign in_ready  = mul_ready;

   // partial products of x times the inverse gain
   always_comb begin
      hi_src = in_data.cx[CORDIC_BITS-2:LO_SPLIT];
      lo_src = in_data.cx[LO_SPLIT-1:0];
      hi_in  = HI_PROD_BITS'(hi_src) * HI_PROD_BITS'(INV_GAIN);
      lo_in  = LO_PROD_BITS'(lo_src) * LO_PROD_BITS'(INV_GAIN);
   end

   // clamp to the first quadrant, then place by the input signs
   always_comb begin
      if (in_data.z[ZACC_BITS-1]) begin
         z_clamp = '0;
      end else if (in_data.z > signed'(QUARTER_TURN)) begin
         z_clamp = QUARTER_TURN;
      end else begin
         z_clamp = in_data.z;
      end

      if (in_data.side.x_zero) begin
         ang_in = in_data.side.y_neg ? THREEQ_TURN : QUARTER_TURN;
      end else if (in_data.side.y_zero) begin
         ang_in = in_data.side.x_neg ? HALF_TURN : '0;
      end else if (!in_data.side.x_neg && !in_data.side.y_neg) begin
         ang_in = z_clamp;
      end else if (in_data.side.x_neg && !in_data.side.y_neg) begin
         ang_in = HALF_TURN - z_clamp;
      end else if (in_data.side.x_neg) begin
         ang_in = HALF_TURN + z_clamp;
      end else begin
         ang_in = '0 - z_clamp;
      end
   end

   // multiply stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   // multiply stage payload
   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         hi_ff   <= hi_in;
         lo_ff   <= lo_in;
         ang_ff  <= ang_in;
         side_ff <= in_data.side;
      end
   end

   // sum partial products, round and saturate; round the angle; fixed results at the origin
   always_comb begin
      mag_sum   = SUM_BITS'(hi_ff) + SUM_BITS'(lo_ff >> LO_SPLIT) + MAG_ROUND;
      mag_wide  = mag_sum[SUM_BITS-1:MAG_SHIFT];
      ang_round = {1'b0, ang_ff} + ANGLE_ROUND;

      if (side_ff.origin) begin
         mag_in   = MAG_ONE;
         angle_in = '0;
         xfl_in   = XFLOOR_ORIGIN;
      end else begin
         mag_in   = (mag_wide > MAG_MAX) ? MAG_MAX[COORD_BITS-1:0]
                                         : mag_wide[COORD_BITS-1:0];
         angle_in = ang_round[ZACC_BITS-1 -: ANGLE_BITS];
         xfl_in   = side_ff.x_floor;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ready) begin
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (rsp_ready && mul_valid_ff) begin
         mag_ff   <= mag_in;
         angle_ff <= angle_in;
         xfl_ff   <= xfl_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign magnitude = mag_ff;
   assign angle     = angle_ff;
   assign x_floor   = signed'(xfl_ff);
endmodule

FILE: rtl/core/cartesian_to_polar_core.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar_core
// magnitude, full-circle angle and x floor of a Q15.4 point
// ----------------------------------------------------------------------------
//
//   channel    dir  payload                              transfer
//   req_chan   in   x_coord, y_coord                     valid && ready
//   rsp_chan   out  magnitude, angle, x_floor            valid && ready
//
// a point passes these registers in order from request to response:
// input stage, one stage per cordic rotation, multiply stage, output register
// one request can be taken every cycle; every stage holds its point while the
// stage after it is full and stalled, empty stages still fill
// synchronous reset clears the stage valid bits only
//
`include "cartesian_to_polar_core_defines.svh"

module cartesian_to_polar_core (
   input logic        clock,
   input logic        reset,
   c2p_req_if.sink    req_chan,
   c2p_rsp_if.source  rsp_chan
);
   import c2p_pkg::*;

   logic       prep_valid;
   logic       prep_ready;
   cordic_type prep_data;
   logic       cord_valid;
   logic       cord_ready;
   cordic_type cord_data;
   logic       rsp_idle;
   logic       left_pt;
   logic       right_pt;
   logic       left_ang;
   logic       right_ang;
   logic       zero_mag;

   // folding and flags
   c2p_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .x_coord   (req_chan.x_coord),
      .y_coord   (req_chan.y_coord),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   // rotation pipeline
   c2p_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (cord_valid),
      .out_ready (cord_ready),
      .out_data  (cord_data)
   );

   // gain, quadrant and output register
   c2p_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cord_valid),
      .in_ready  (cord_ready),
      .in_data   (cord_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .magnitude (rsp_chan.magnitude),
      .angle     (rsp_chan.angle),
      .x_floor   (rsp_chan.x_floor)
   );

   // response conditions watched by the checks below
   assign rsp_idle  = !rsp_chan.valid;
   assign left_pt   = rsp_chan.valid && rsp_chan.x_floor[XFLOOR_BITS-1];
   assign right_pt  = rsp_chan.valid && !rsp_chan.x_floor[XFLOOR_BITS-1];
   assign left_ang  = (rsp_chan.angle >= ANGLE_QUARTER) && (rsp_chan.angle <= ANGLE_THREEQ);
   assign right_ang = (rsp_chan.angle <= ANGLE_QUARTER) || (rsp_chan.angle >= ANGLE_THREEQ);
   assign zero_mag  = rsp_chan.valid && (rsp_chan.magnitude == '0);

   // an empty output register lets the whole pipe move
   `C2P_ASSERT_IMPLIES(a_ready_when_drained, clock, reset, rsp_idle, req_chan.ready, "blocked")
   // negative x lies in the left half plane
   `C2P_ASSERT_IMPLIES(a_left_half, clock, reset, left_pt, left_ang, "angle not in left half")
   // non-negative x lies in the right half plane
   `C2P_ASSERT_IMPLIES(a_right_half, clock, reset, right_pt, right_ang, "angle not in right half")
   // every point has a nonzero length
   `C2P_ASSERT_NEVER(a_mag_nonzero, clock, reset, zero_mag, "zero magnitude")
endmodule
